[src/set_assoc_writeback_cache_unit_macros.svh]
// Assertion macros shared by the cache unit RTL.
// Included by the files that carry concurrent checks; needs no other file.
`ifndef SET_ASSOC_WRITEBACK_CACHE_UNIT_MACROS_SVH
`define SET_ASSOC_WRITEBACK_CACHE_UNIT_MACROS_SVH

`ifndef SYNTH
// Property that holds in the same cycle, checked outside reset.
`define SAWC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("cache unit check failed");
// Condition in one cycle that implies a consequence in the next cycle.
`define SAWC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cache unit sequencing check failed");
`else
`define SAWC_ASSERT(lbl, clk, rst_n, prop)
`define SAWC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[src/sawc_pkg.sv]
// Shared constants, types and state codes of the set-associative cache unit.
// Used by the top level; depends on nothing else.
package sawc_pkg;

    // Cache geometry and counter size.
    localparam int WAYS       = 2;
    localparam int SETS       = 8;
    localparam int LINE_BYTES = 8;
    localparam int MEM_BYTES  = 4096;
    localparam int COUNT_BITS = 16;

    // Fixed field widths of the access and result items.
    localparam int ADDR_W = 12;
    localparam int BYTE_W = 8;

    // Derived widths.
    localparam int OFF_W   = $clog2(LINE_BYTES);
    localparam int SET_W   = $clog2(SETS);
    localparam int TAG_W   = ADDR_W - OFF_W - SET_W;
    localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int ROWS    = MEM_BYTES / LINE_BYTES;
    localparam int ROW_W   = $clog2(ROWS);
    localparam int LINE_W  = LINE_BYTES * BYTE_W;

    // Stream payload widths, padded to whole bytes.
    localparam int IN_DATA_W  = ADDR_W + BYTE_W;
    localparam int IN_TDATA_W = ((IN_DATA_W + 7) / 8) * 8;

    typedef logic [LINE_BYTES-1:0][BYTE_W-1:0] t_line;

    // One way of a set as kept in the set memory.
    typedef struct packed {
        logic                  dirty;
        logic [COUNT_BITS-1:0] count;
        logic [TAG_W-1:0]      tag;
        t_line                 bytes;
    } t_way;

    typedef t_way [WAYS-1:0] t_set_row;

    localparam int SET_ROW_W = $bits(t_set_row);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // Result item, last field in the lowest bits.
    typedef struct packed {
        logic              wrote_back;
        logic [BYTE_W-1:0] byte_value;
        logic              way_used;
        logic [2:0]        set_index;
        logic              hit;
    } t_result;

    localparam int OUT_DATA_W  = $bits(t_result);
    localparam int OUT_TDATA_W = ((OUT_DATA_W + 7) / 8) * 8;

    // Access kinds.
    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP,
        S_RESP
    } t_state;

endpackage

[src/sawc_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; instantiated for the set memory and the backing memory.
module sawc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered, updated only while the read enable is high.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/set_assoc_writeback_cache_unit.sv]
// Two-way set-associative write-back cache with least-used replacement and
// a line-wide backing memory inside the block.
// Depends on sawc_pkg, sawc_ram and the assertion macro header.
// Results: an accepted item passes the lookup and response states, and its result
// is registered to the master side once the output register is free.
// Items: a new item is taken only in the idle state, after the read, update and
// write-back of the set memory for the last one (the backing line is read alongside).
// Reset: synchronous, active low; line valid bits clear at once, then a
// clearing pass writes all ROWS (512) rows of the backing memory with s_axis_tready low.
`include "set_assoc_writeback_cache_unit_macros.svh"

module set_assoc_writeback_cache_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Access items.
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // tdata: address [11:0], write_data [19:12], zero padding above.
    input  logic [sawc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // tuser: kind (0 read, 1 write).
    input  logic                             s_axis_tuser,
    // Result items.
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // tdata: hit [0], set_index [3:1], way_used [4], byte_value [12:5],
    // wrote_back [13], zero padding above.
    output logic [sawc_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int OFF_W  = sawc_pkg::OFF_W;
    localparam int SET_W  = sawc_pkg::SET_W;
    localparam int TAG_W  = sawc_pkg::TAG_W;
    localparam int WAY_W  = sawc_pkg::WAY_W;
    localparam int ROW_W  = sawc_pkg::ROW_W;
    localparam int ADDR_W = sawc_pkg::ADDR_W;
    localparam int BYTE_W = sawc_pkg::BYTE_W;
    localparam int WAYS   = sawc_pkg::WAYS;
    localparam int SETS   = sawc_pkg::SETS;

    // Control state.
    sawc_pkg::t_state r_state, n_state;
    logic [ROW_W-1:0] r_clr_row, n_clr_row;
    logic [SETS-1:0][WAYS-1:0] r_valid;
    logic r_out_valid, n_out_valid;

    // Captured access and pending result.
    logic              r_kind;
    logic [ADDR_W-1:0] r_addr;
    logic [BYTE_W-1:0] r_wdata;
    sawc_pkg::t_result r_res, n_res;
    sawc_pkg::t_result r_out;

    // Memory ports.
    logic                           set_re, set_we;
    logic [SET_W-1:0]               set_raddr;
    sawc_pkg::t_set_row             set_rdata, set_wdata;
    logic                           bk_re, bk_we;
    logic [ROW_W-1:0]               bk_raddr, bk_waddr;
    sawc_pkg::t_line                bk_rdata, bk_wdata, clr_line;

    // Lookup datapath.
    logic [OFF_W-1:0]   r_off;
    logic [SET_W-1:0]   r_set;
    logic [TAG_W-1:0]   r_tag;
    logic [SET_W-1:0]   in_set;
    sawc_pkg::t_set_row eff_row, new_row;
    sawc_pkg::t_way     new_entry, victim;
    logic               hit, any_inv, wb;
    logic [WAY_W-1:0]   hit_way, inv_way, lru_way, sel_way;
    logic [sawc_pkg::COUNT_BITS-1:0] low_count;
    logic [BYTE_W-1:0]  value;
    logic               accept, out_free;

    assign r_off  = r_addr[OFF_W-1:0];
    assign r_set  = r_addr[OFF_W +: SET_W];
    assign r_tag  = r_addr[OFF_W + SET_W +: TAG_W];
    assign in_set = s_axis_tdata[OFF_W +: SET_W];

    assign s_axis_tready = (r_state == sawc_pkg::S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;

    // Set memory: both ways of a set in one row.
    sawc_ram #(
        .WIDTH(sawc_pkg::SET_ROW_W),
        .DEPTH(SETS)
    ) u_set_ram (
        .i_clk  (i_clk),
        .i_we   (set_we),
        .i_waddr(r_set),
        .i_wdata(set_wdata),
        .i_re   (set_re),
        .i_raddr(set_raddr),
        .o_rdata(set_rdata)
    );

    // Backing memory: one line per row.
    sawc_ram #(
        .WIDTH(sawc_pkg::LINE_W),
        .DEPTH(sawc_pkg::ROWS)
    ) u_backing_ram (
        .i_clk  (i_clk),
        .i_we   (bk_we),
        .i_waddr(bk_waddr),
        .i_wdata(bk_wdata),
        .i_re   (bk_re),
        .i_raddr(bk_raddr),
        .o_rdata(bk_rdata)
    );

    // Reset contents of the backing row under the clearing pass.
    always_comb begin
        for (int j = 0; j < sawc_pkg::LINE_BYTES; j++) begin
            clr_line[j] = BYTE_W'({r_clr_row, OFF_W'(j)});
        end
    end

    // Hit check, victim choice and line update for the looked-up set.
    always_comb begin
        eff_row = set_rdata;
        for (int i = 0; i < WAYS; i++) begin
            if (!r_valid[r_set][i]) begin
                eff_row[i] = '0;
            end
        end

        // Lowest matching way wins.
        hit     = 1'b0;
        hit_way = '0;
        any_inv = 1'b0;
        inv_way = '0;
        for (int i = WAYS - 1; i >= 0; i--) begin
            if (r_valid[r_set][i] && (eff_row[i].tag == r_tag)) begin
                hit     = 1'b1;
                hit_way = WAY_W'(i);
            end
            if (!r_valid[r_set][i]) begin
                any_inv = 1'b1;
                inv_way = WAY_W'(i);
            end
        end

        // Least used way, ties to the lower way.
        lru_way   = '0;
        low_count = eff_row[0].count;
        for (int i = 1; i < WAYS; i++) begin
            if (eff_row[i].count < low_count) begin
                low_count = eff_row[i].count;
                lru_way   = WAY_W'(i);
            end
        end

        if (hit) begin
            sel_way = hit_way;
        end else if (any_inv) begin
            sel_way = inv_way;
        end else begin
            sel_way = lru_way;
        end

        victim = eff_row[lru_way];
        wb     = !hit && !any_inv && victim.dirty;

        // A miss fills the line from the backing row read alongside.
        new_entry = eff_row[sel_way];
        if (!hit) begin
            new_entry.bytes = bk_rdata;
            new_entry.tag   = r_tag;
            new_entry.dirty = 1'b0;
        end
        if (new_entry.count != sawc_pkg::COUNT_MAX) begin
            new_entry.count = new_entry.count + 1'b1;
        end
        if (r_kind == sawc_pkg::KIND_WRITE) begin
            new_entry.bytes[r_off] = r_wdata;
            new_entry.dirty        = 1'b1;
            value                  = r_wdata;
        end else begin
            value = new_entry.bytes[r_off];
        end

        new_row          = eff_row;
        new_row[sel_way] = new_entry;

        n_res.hit        = hit;
        n_res.set_index  = 3'(r_set);
        n_res.way_used   = sel_way[0];
        n_res.byte_value = value;
        n_res.wrote_back = wb;
    end

    // Sequencer: next state and memory controls.
    always_comb begin
        n_state     = r_state;
        n_clr_row   = r_clr_row;
        n_out_valid = r_out_valid;
        set_re      = 1'b0;
        set_we      = 1'b0;
        set_raddr   = in_set;
        set_wdata   = new_row;
        bk_re       = 1'b0;
        bk_we       = 1'b0;
        bk_raddr    = ROW_W'(s_axis_tdata[ADDR_W-1:OFF_W]);
        bk_waddr    = ROW_W'({victim.tag, r_set});
        bk_wdata    = victim.bytes;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            sawc_pkg::S_CLEAR: begin
                bk_we     = 1'b1;
                bk_waddr  = r_clr_row;
                bk_wdata  = clr_line;
                n_clr_row = r_clr_row + 1'b1;
                if (r_clr_row == ROW_W'(sawc_pkg::ROWS - 1)) begin
                    n_state = sawc_pkg::S_IDLE;
                end
            end
            sawc_pkg::S_IDLE: begin
                if (accept) begin
                    set_re  = 1'b1;
                    bk_re   = 1'b1;
                    n_state = sawc_pkg::S_LOOKUP;
                end
            end
            sawc_pkg::S_LOOKUP: begin
                set_we  = 1'b1;
                bk_we   = wb;
                n_state = sawc_pkg::S_RESP;
            end
            sawc_pkg::S_RESP: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = sawc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sawc_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sawc_pkg::S_CLEAR;
            r_clr_row   <= '0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_row   <= n_clr_row;
            r_out_valid <= n_out_valid;
            if (r_state == sawc_pkg::S_LOOKUP) begin
                r_valid[r_set][sel_way] <= 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind  <= s_axis_tuser;
            r_addr  <= s_axis_tdata[ADDR_W-1:0];
            r_wdata <= s_axis_tdata[ADDR_W +: BYTE_W];
        end
        if (r_state == sawc_pkg::S_LOOKUP) begin
            r_res <= n_res;
        end
        if ((r_state == sawc_pkg::S_RESP) && out_free) begin
            r_out <= r_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(sawc_pkg::OUT_TDATA_W - sawc_pkg::OUT_DATA_W)'(0), r_out};

    // An accepted item goes straight to the set lookup.
    `SAWC_ASSERT_NEXT(a_accept_to_lookup, i_clk, i_rst_n, accept, r_state == sawc_pkg::S_LOOKUP)
    // No result leaves while the backing memory is being cleared.
    `SAWC_ASSERT(a_quiet_in_clear, i_clk, i_rst_n, (r_state == sawc_pkg::S_CLEAR) |-> !m_axis_tvalid)
    // A writeback only happens on a miss.
    `SAWC_ASSERT(a_wb_on_miss, i_clk, i_rst_n, m_axis_tvalid |-> !(r_out.hit && r_out.wrote_back))
    // A finished result waits while the output register is still full.
    `SAWC_ASSERT_NEXT(a_resp_waits, i_clk, i_rst_n, (r_state == sawc_pkg::S_RESP) && r_out_valid && !m_axis_tready, r_state == sawc_pkg::S_RESP)
    // Line valid bits are never dropped by a lookup.
    `SAWC_ASSERT_NEXT(a_valid_sticky, i_clk, i_rst_n, r_state == sawc_pkg::S_LOOKUP, (r_valid & $past(r_valid)) == $past(r_valid))

endmodule
